>>> hw/rtl/fn3d_pkg.sv
package fn3d_pkg;

	localparam int FRAC     = 16;
	localparam int COORD_W  = 32;
	localparam int OUT_W    = 18;
	localparam int CFG_W    = 32;
	localparam int CIDX_W   = 4;
	localparam int OCT_W    = 5;
	localparam int OCNT_W   = 6;
	localparam int SEED_W   = 32;
	localparam int FSTEP_W  = 18;
	localparam int ASTEP_W  = 17;
	localparam int FREQ_W   = 48;
	localparam int AMP_W    = 17;
	localparam int CORNER_W = 19;
	localparam int FADE_W   = 17;
	localparam int MUL_W    = 33;
	localparam int PROD_W   = 66;

	localparam int MAX_OCTAVES_DEF = 16;

	localparam logic [CIDX_W-1:0] REG_OCTAVE_COUNT = 4'd0;
	localparam logic [CIDX_W-1:0] REG_BASE_SEED    = 4'd1;
	localparam logic [CIDX_W-1:0] REG_FREQ_STEP    = 4'd2;
	localparam logic [CIDX_W-1:0] REG_AMP_STEP     = 4'd3;

	localparam logic [OCT_W-1:0]   OCTAVE_COUNT_RST = 5'd4;
	localparam logic [SEED_W-1:0]  BASE_SEED_RST    = 32'd0;
	localparam logic [FSTEP_W-1:0] FREQ_STEP_RST    = 18'd131072;
	localparam logic [ASTEP_W-1:0] AMP_STEP_RST     = 17'd32768;

	localparam logic [SEED_W-1:0] H_SEED     = 32'h9E3779B9;
	localparam logic [SEED_W-1:0] H_X        = 32'h85EBCA6B;
	localparam logic [SEED_W-1:0] H_Y        = 32'hC2B2AE35;
	localparam logic [SEED_W-1:0] H_Z        = 32'h27D4EB2F;
	localparam logic [SEED_W-1:0] H_MIX1     = 32'h2C1B3C6D;
	localparam logic [SEED_W-1:0] H_MIX2     = 32'h297A2D39;
	localparam logic [SEED_W-1:0] SEED_STEP  = 32'd1013;

	localparam logic [FREQ_W-1:0]          FREQ_ONE   = 48'd65536;
	localparam logic [AMP_W-1:0]           AMP_ONE    = 17'd65536;
	localparam logic [FADE_W-1:0]          FADE_ONE   = 17'd65536;
	localparam logic signed [CORNER_W-1:0] CORNER_ONE = 19'sd65536;
	localparam logic signed [20:0]         FADE_15    = 21'sd983040;
	localparam logic signed [20:0]         FADE_10    = 21'sd655360;

	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic signed [CORNER_W-1:0] grad_dot(input logic [3:0] g,
			input logic signed [CORNER_W-1:0] x, input logic signed [CORNER_W-1:0] y,
			input logic signed [CORNER_W-1:0] z);
		logic signed [CORNER_W-1:0] r;
		unique case (g)
			4'd0, 4'd12: r = x + y;
			4'd1, 4'd14: r = y - x;
			4'd2:        r = x - y;
			4'd3:        r = -x - y;
			4'd4:        r = x + z;
			4'd5:        r = z - x;
			4'd6:        r = x - z;
			4'd7:        r = -x - z;
			4'd8:        r = y + z;
			4'd9, 4'd13: r = z - y;
			4'd10:       r = y - z;
			default:     r = -y - z;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/fn3d_div.sv
module fn3d_div #(
	parameter int DVD_W = 40,
	parameter int DVS_W = 21
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DVD_W-1:0]  dividend,
	input  logic        [DVS_W-1:0]  divisor,
	output fn3d_pkg::div_stat_t      stat,
	output logic signed [DVD_W-1:0]  quotient
);
	import fn3d_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic             neg_q;
	logic [DVS_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[DVD_W-1];
			quo_q <= dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DVS_W'(trial - {1'b0, dvs_q}) : DVS_W'(trial);
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

>>> hw/rtl/fractal_noise_3d.sv
// Channel   Signals                              Moves
// in        in_valid/in_ready, x/y/z_coord       one sample point request
// out       out_valid/out_ready, noise_value     one noise result
// cfg       cfg_we, cfg_index, cfg_data          register write, no wait
//
// A request passes the idle state, then for each octave the scale, hash, corner,
// fade, blend and accumulate states (one shared 33x33 multiplier, one product per
// cycle), a final bit-serial division and the result load. Zero octaves skip to done.
// in_ready is high only while idle. A finished result waits in the output register;
// the next request is taken while it waits, and holds in its last cycle until the
// output register frees. Reset clears control state and loads register defaults.
module fractal_noise_3d #(
	parameter int MAX_OCTAVES = fn3d_pkg::MAX_OCTAVES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [fn3d_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [fn3d_pkg::COORD_W-1:0]  y_coord,
	input  logic signed [fn3d_pkg::COORD_W-1:0]  z_coord,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [fn3d_pkg::OUT_W-1:0]    noise_value,
	input  logic                                 cfg_we,
	input  logic        [fn3d_pkg::CIDX_W-1:0]   cfg_index,
	input  logic        [fn3d_pkg::CFG_W-1:0]    cfg_data
);
	import fn3d_pkg::*;

	localparam int SUM_W  = 36 + $clog2(MAX_OCTAVES);
	localparam int NORM_W = 17 + $clog2(MAX_OCTAVES);
	localparam logic [OCNT_W-1:0]      MAX_OCT = OCNT_W'(MAX_OCTAVES);
	localparam logic signed [SUM_W-1:0] Q_MAX  = SUM_W'(OUT_MAX);
	localparam logic signed [SUM_W-1:0] Q_MIN  = SUM_W'(OUT_MIN);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SCALE  = 9'b000000010,
		ST_HASH   = 9'b000000100,
		ST_CORNER = 9'b000001000,
		ST_FADE   = 9'b000010000,
		ST_BLEND  = 9'b000100000,
		ST_ACCUM  = 9'b001000000,
		ST_DIV    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [2:0]          sub_q;
	logic [2:0]          idx_q;
	logic [OCNT_W-1:0]   cnt_q;
	logic                out_valid_q;
	logic [OCT_W-1:0]    octave_count_q;
	logic [SEED_W-1:0]   base_seed_q;
	logic [FSTEP_W-1:0]  freq_step_q;
	logic [ASTEP_W-1:0]  amp_step_q;

	logic signed [COORD_W-1:0]  x_q, y_q, z_q;
	logic [FREQ_W-1:0]          freq_q;
	logic [AMP_W-1:0]           amp_q;
	logic [SEED_W-1:0]          seed_q;
	logic [63:0]                acc_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic [31:0]                ix_q, iy_q, iz_q;
	logic [FRAC-1:0]            dx_q, dy_q, dz_q;
	logic [31:0]                hs_q, hx0_q, hx1_q, hy0_q, hy1_q, hz0_q, hz1_q;
	logic signed [CORNER_W-1:0] c_q [8];
	logic signed [20:0]         b_q;
	logic [FADE_W-1:0]          u_q, v_q, w_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [NORM_W-1:0]          norm_q;
	logic signed [OUT_W-1:0]    res_q;
	logic signed [OUT_W-1:0]    noise_q;

	logic [OCNT_W-1:0]          n_oct;
	logic [AMP_W-1:0]           gain;
	logic                       accept;
	logic                       out_load;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [COORD_W-1:0]  coord_sel;
	logic [FRAC-1:0]            t_sel;
	logic signed [20:0]         fa;
	logic [63:0]                comb64;
	logic [31:0]                h0, h0m, h1m, h2, h2m;
	logic signed [CORNER_W-1:0] cx, cy, cz, dot;
	logic signed [19:0]         diff;
	logic [FADE_W-1:0]          bt;
	logic signed [20:0]         bres;
	logic [2:0]                 wr_pos;
	logic [FADE_W-1:0]          fade_val;
	logic                       div_start;
	div_stat_t                  div_stat;
	logic signed [SUM_W-1:0]    quot;
	logic signed [OUT_W-1:0]    quot_sat;

	assign n_oct    = ({1'b0, octave_count_q} > MAX_OCT) ? MAX_OCT : {1'b0, octave_count_q};
	assign gain     = (amp_step_q > AMP_ONE) ? AMP_ONE : amp_step_q;
	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign div_start = (state_q == ST_DIV) && (sub_q == 3'd0);
	assign out_valid   = out_valid_q;
	assign noise_value = noise_q;

	always_comb begin
		unique case (idx_q[1:0])
			2'd0:    begin coord_sel = x_q; t_sel = dx_q; end
			2'd1:    begin coord_sel = y_q; t_sel = dy_q; end
			default: begin coord_sel = z_q; t_sel = dz_q; end
		endcase
	end

	assign fa     = $signed(21'({t_sel, 2'b00}) + 21'({t_sel, 1'b0})) - FADE_15;
	assign comb64 = acc_q + {prod_q[39:0], 24'b0};

	assign h0  = hs_q ^ (idx_q[0] ? hx1_q : hx0_q) ^ (idx_q[1] ? hy1_q : hy0_q)
		^ (idx_q[2] ? hz1_q : hz0_q);
	assign h0m = h0 ^ (h0 >> 15);
	assign h1m = prod_q[31:0] ^ (prod_q[31:0] >> 12);
	assign h2  = prod_q[31:0];
	assign h2m = h2 ^ (h2 >> 15);

	assign cx  = $signed({3'b000, dx_q}) - (idx_q[0] ? CORNER_ONE : '0);
	assign cy  = $signed({3'b000, dy_q}) - (idx_q[1] ? CORNER_ONE : '0);
	assign cz  = $signed({3'b000, dz_q}) - (idx_q[2] ? CORNER_ONE : '0);
	assign dot = grad_dot(h2m[3:0], cx, cy, cz);

	assign diff   = 20'(c_q[1]) - 20'(c_q[0]);
	assign bt     = (idx_q < 3'd4) ? u_q : ((idx_q < 3'd6) ? v_q : w_q);
	assign bres   = 21'(c_q[0]) + $signed(prod_q[36:16]);
	assign wr_pos = 3'd6 - idx_q;

	always_comb begin
		if (prod_q[PROD_W-1])
			fade_val = '0;
		else if (prod_q[48:16] > 33'(FADE_ONE))
			fade_val = FADE_ONE;
		else
			fade_val = prod_q[32:16];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SCALE: begin
				mul_a = MUL_W'(coord_sel);
				mul_b = (sub_q == 3'd0) ? MUL_W'(freq_q[23:0]) : MUL_W'(freq_q[47:24]);
			end
			ST_HASH: begin
				unique case (sub_q)
					3'd0: begin mul_a = MUL_W'(seed_q); mul_b = MUL_W'(H_SEED); end
					3'd1: begin mul_a = MUL_W'(ix_q);   mul_b = MUL_W'(H_X);    end
					3'd2: begin mul_a = MUL_W'(iy_q);   mul_b = MUL_W'(H_Y);    end
					3'd3: begin mul_a = MUL_W'(iz_q);   mul_b = MUL_W'(H_Z);    end
					default: ;
				endcase
			end
			ST_CORNER: begin
				unique case (sub_q)
					3'd0: begin mul_a = MUL_W'(h0m); mul_b = MUL_W'(H_MIX1); end
					3'd1: begin mul_a = MUL_W'(h1m); mul_b = MUL_W'(H_MIX2); end
					default: ;
				endcase
			end
			ST_FADE: begin
				unique case (sub_q)
					3'd0: begin mul_a = MUL_W'(t_sel);          mul_b = MUL_W'(fa);    end
					3'd1: begin mul_a = MUL_W'(t_sel);          mul_b = MUL_W'(t_sel); end
					3'd2: begin mul_a = MUL_W'(prod_q[31:16]);  mul_b = MUL_W'(t_sel); end
					3'd3: begin mul_a = MUL_W'(prod_q[31:16]);  mul_b = MUL_W'(b_q);   end
					default: ;
				endcase
			end
			ST_BLEND: begin
				mul_a = MUL_W'(diff);
				mul_b = MUL_W'(bt);
			end
			ST_ACCUM: begin
				unique case (sub_q)
					3'd0: begin mul_a = MUL_W'(c_q[0]);        mul_b = MUL_W'(amp_q);       end
					3'd1: begin mul_a = MUL_W'(amp_q);         mul_b = MUL_W'(gain);        end
					3'd2: begin mul_a = MUL_W'(freq_q[23:0]);  mul_b = MUL_W'(freq_step_q); end
					3'd3: begin mul_a = MUL_W'(freq_q[47:24]); mul_b = MUL_W'(freq_step_q); end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		if (quot > Q_MAX)
			quot_sat = OUT_W'(Q_MAX);
		else if (quot < Q_MIN)
			quot_sat = OUT_W'(Q_MIN);
		else
			quot_sat = OUT_W'(quot);
	end

	fn3d_div #(
		.DVD_W(SUM_W),
		.DVS_W(NORM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (norm_q),
		.stat     (div_stat),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sub_q          <= '0;
			idx_q          <= '0;
			cnt_q          <= '0;
			out_valid_q    <= 1'b0;
			octave_count_q <= OCTAVE_COUNT_RST;
			base_seed_q    <= BASE_SEED_RST;
			freq_step_q    <= FREQ_STEP_RST;
			amp_step_q     <= AMP_STEP_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_OCTAVE_COUNT: octave_count_q <= cfg_data[OCT_W-1:0];
					REG_BASE_SEED:    base_seed_q    <= cfg_data[SEED_W-1:0];
					REG_FREQ_STEP:    freq_step_q    <= cfg_data[FSTEP_W-1:0];
					REG_AMP_STEP:     amp_step_q     <= cfg_data[ASTEP_W-1:0];
					default: ;
				endcase
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sub_q   <= '0;
						idx_q   <= '0;
						cnt_q   <= '0;
						state_q <= (n_oct == '0) ? ST_DONE : ST_SCALE;
					end
				end
				ST_SCALE: begin
					if (sub_q == 3'd2) begin
						sub_q <= '0;
						if (idx_q == 3'd2) begin
							idx_q   <= '0;
							state_q <= ST_HASH;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				ST_HASH: begin
					if (sub_q == 3'd4) begin
						sub_q   <= '0;
						state_q <= ST_CORNER;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				ST_CORNER: begin
					if (sub_q == 3'd2) begin
						sub_q <= '0;
						idx_q <= idx_q + 1'b1;
						if (idx_q == 3'd7)
							state_q <= ST_FADE;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				ST_FADE: begin
					if (sub_q == 3'd4) begin
						sub_q <= '0;
						if (idx_q == 3'd2) begin
							idx_q   <= '0;
							state_q <= ST_BLEND;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				ST_BLEND: begin
					if (sub_q == 3'd1) begin
						sub_q <= '0;
						if (idx_q == 3'd6) begin
							idx_q   <= '0;
							state_q <= ST_ACCUM;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				ST_ACCUM: begin
					if (sub_q == 3'd4) begin
						sub_q <= '0;
						cnt_q <= cnt_q + 1'b1;
						state_q <= (cnt_q + 1'b1 == n_oct) ? ST_DIV : ST_SCALE;
					end else begin
						sub_q <= sub_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (sub_q == 3'd0) begin
						sub_q <= 3'd1;
					end else if (div_stat.done) begin
						sub_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a * mul_b);
		if (out_load)
			noise_q <= res_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q    <= x_coord;
					y_q    <= y_coord;
					z_q    <= z_coord;
					freq_q <= FREQ_ONE;
					amp_q  <= AMP_ONE;
					seed_q <= base_seed_q;
					sum_q  <= '0;
					norm_q <= '0;
					res_q  <= '0;
				end
			end
			ST_SCALE: begin
				if (sub_q == 3'd1)
					acc_q <= prod_q[63:0];
				if (sub_q == 3'd2) begin
					unique case (idx_q[1:0])
						2'd0:    begin ix_q <= comb64[63:32]; dx_q <= comb64[31:16]; end
						2'd1:    begin iy_q <= comb64[63:32]; dy_q <= comb64[31:16]; end
						default: begin iz_q <= comb64[63:32]; dz_q <= comb64[31:16]; end
					endcase
				end
			end
			ST_HASH: begin
				unique case (sub_q)
					3'd1: hs_q <= prod_q[31:0];
					3'd2: begin hx0_q <= prod_q[31:0]; hx1_q <= prod_q[31:0] + H_X; end
					3'd3: begin hy0_q <= prod_q[31:0]; hy1_q <= prod_q[31:0] + H_Y; end
					3'd4: begin hz0_q <= prod_q[31:0]; hz1_q <= prod_q[31:0] + H_Z; end
					default: ;
				endcase
			end
			ST_CORNER: begin
				if (sub_q == 3'd2) begin
					for (int i = 0; i < 7; i++)
						c_q[i] <= c_q[i+1];
					c_q[7] <= dot;
				end
			end
			ST_FADE: begin
				if (sub_q == 3'd1)
					b_q <= $signed(prod_q[36:16]) + FADE_10;
				if (sub_q == 3'd4) begin
					unique case (idx_q[1:0])
						2'd0:    u_q <= fade_val;
						2'd1:    v_q <= fade_val;
						default: w_q <= fade_val;
					endcase
				end
			end
			ST_BLEND: begin
				if (sub_q == 3'd1) begin
					for (int i = 0; i < 8; i++) begin
						if (3'(i) == wr_pos)
							c_q[i] <= bres[CORNER_W-1:0];
						else if (i < 6)
							c_q[i] <= c_q[(i + 2) % 8];
					end
				end
			end
			ST_ACCUM: begin
				unique case (sub_q)
					3'd1: begin
						sum_q  <= sum_q + $signed(prod_q[SUM_W-1:0]);
						norm_q <= norm_q + NORM_W'(amp_q);
					end
					3'd2: amp_q <= prod_q[32:16];
					3'd3: acc_q <= prod_q[63:0];
					3'd4: begin
						freq_q <= comb64[63:16];
						seed_q <= seed_q + SEED_STEP;
					end
					default: ;
				endcase
			end
			ST_DIV: begin
				if (div_stat.done)
					res_q <= quot_sat;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCALE || state_q == ST_ACCUM) |-> cnt_q < n_oct)
		else $error("octave counter beyond octave count");
	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> norm_q != '0)
		else $error("division started with zero norm");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("ready right after a request was taken");
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");
	a_div_idle_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> !div_stat.busy)
		else $error("divider still busy when result is ready");
`endif

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import fn3d_pkg::*;

	typedef struct {
		int unsigned           octs;
		logic signed [31:0]    x;
		logic signed [31:0]    y;
		logic signed [31:0]    z;
		bit                    pin;
		logic signed [17:0]    val;
	} point_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	logic signed [COORD_W-1:0] x_coord, y_coord, z_coord;
	logic signed [OUT_W-1:0] noise_value;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	logic [OCT_W-1:0]   octave_cnt;
	logic [SEED_W-1:0]  seed_reg;
	logic [FSTEP_W-1:0] lacunarity;
	logic [ASTEP_W-1:0] gain_reg;

	logic signed [OUT_W-1:0] noise_q[$];
	bit pinned;
	logic signed [OUT_W-1:0] pinned_val;
	int errors, accepted, results, phases;
	bit jitter;
	int stall_req, stall_seen, hold_left;

	fractal_noise_3d u_top (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic logic [31:0] lattice_hash(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] s);
		logic [31:0] h;
		h = s * H_SEED;
		h ^= x * H_X;
		h ^= y * H_Y;
		h ^= z * H_Z;
		h ^= h >> 15;
		h *= H_MIX1;
		h ^= h >> 12;
		h *= H_MIX2;
		h ^= h >> 15;
		return h;
	endfunction

	function automatic longint grad_of(input logic [3:0] g, input longint x, input longint y,
			input longint z);
		case (g)
			4'd0, 4'd12: return x + y;
			4'd1, 4'd14: return y - x;
			4'd2:        return x - y;
			4'd3:        return -x - y;
			4'd4:        return x + z;
			4'd5:        return z - x;
			4'd6:        return x - z;
			4'd7:        return -x - z;
			4'd8:        return y + z;
			4'd9, 4'd13: return z - y;
			4'd10:       return y - z;
			default:     return -y - z;
		endcase
	endfunction

	function automatic longint fade_of(input longint t);
		longint a, b, t3, f;
		a = 6 * t - 15 * 65536;
		b = ((t * a) >>> 16) + 10 * 65536;
		t3 = (((t * t) >>> 16) * t) >>> 16;
		f = (t3 * b) >>> 16;
		if (f < 0)
			f = 0;
		if (f > 65536)
			f = 65536;
		return f;
	endfunction

	function automatic longint lerp_of(input longint a, input longint b, input longint t);
		return a + (((b - a) * t) >>> 16);
	endfunction

	function automatic longint octave_value(input logic [63:0] sx, input logic [63:0] sy,
			input logic [63:0] sz, input logic [31:0] seed);
		logic [31:0] ix, iy, iz, h;
		longint dx, dy, dz, u, v, w;
		longint c[8];
		dx = longint'(sx[15:0]);
		dy = longint'(sy[15:0]);
		dz = longint'(sz[15:0]);
		ix = sx[47:16];
		iy = sy[47:16];
		iz = sz[47:16];
		for (int i = 0; i < 8; i++) begin
			h = lattice_hash(ix + i[0], iy + i[1], iz + i[2], seed);
			c[i] = grad_of(h[3:0], dx - (i[0] ? 65536 : 0), dy - (i[1] ? 65536 : 0),
				dz - (i[2] ? 65536 : 0));
		end
		u = fade_of(dx);
		v = fade_of(dy);
		w = fade_of(dz);
		return lerp_of(lerp_of(lerp_of(c[0], c[1], u), lerp_of(c[2], c[3], u), v),
			lerp_of(lerp_of(c[4], c[5], u), lerp_of(c[6], c[7], u), v), w);
	endfunction

	function automatic logic signed [OUT_W-1:0] fbm_noise(input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		logic [63:0] xs, ys, zs, freq, amp, gain, p;
		logic [31:0] seed;
		longint sum, norm, r;
		int n;
		xs = {{32{x[31]}}, x};
		ys = {{32{y[31]}}, y};
		zs = {{32{z[31]}}, z};
		n = (octave_cnt > 16) ? 16 : octave_cnt;
		gain = (gain_reg > 17'd65536) ? 64'd65536 : 64'(gain_reg);
		freq = 64'd65536;
		amp = 64'd65536;
		sum = 0;
		norm = 0;
		r = 0;
		seed = seed_reg;
		for (int i = 0; i < n; i++) begin
			sum += longint'(amp) * octave_value((xs * freq) >> 16, (ys * freq) >> 16,
				(zs * freq) >> 16, seed);
			norm += longint'(amp);
			amp = (amp * gain) >> 16;
			p = freq * 64'(lacunarity);
			freq = (p >> 16) & 64'hFFFF_FFFF_FFFF;
			seed = seed + SEED_STEP;
		end
		if (norm > 0) begin
			r = sum / norm;
			if (r > OUT_MAX)
				r = OUT_MAX;
			if (r < OUT_MIN)
				r = OUT_MIN;
		end
		return r[OUT_W-1:0];
	endfunction

	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			noise_q.push_back(pinned ? pinned_val : fbm_noise(x_coord, y_coord, z_coord));
			accepted++;
		end
		if (out_valid && out_ready) begin
			results++;
			if (noise_q.size() == 0) begin
				$error("noise_value: no request pending, actual %0d", noise_value);
				errors++;
			end else if (noise_value !== noise_q[0]) begin
				$error("noise_value: expected %0d, actual %0d", noise_q[0], noise_value);
				errors++;
				void'(noise_q.pop_front());
			end else begin
				void'(noise_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (stall_seen != stall_req) begin
			stall_seen = stall_req;
			hold_left = 1000;
		end
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left--;
		end else begin
			out_ready <= jitter ? ($urandom_range(99) >= 34) : 1'b1;
		end
	end

	task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_OCTAVE_COUNT: octave_cnt = data[OCT_W-1:0];
			REG_BASE_SEED:    seed_reg = data;
			REG_FREQ_STEP:    lacunarity = data[FSTEP_W-1:0];
			REG_AMP_STEP:     gain_reg = data[ASTEP_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (noise_q.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		in_valid <= 1'b1;
		x_coord <= x;
		y_coord <= y;
		z_coord <= z;
		do
			@(posedge clk);
		while (!in_ready);
		if (jitter && $urandom_range(99) < 34) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
			2: return $signed($urandom_range(0, 2 ** 25)) - 2 ** 24;
			default: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
		endcase
	endfunction

	task automatic run_phase(input int unsigned octs, input logic [31:0] seed,
			input logic [31:0] fstep, input logic [31:0] astep, input int cnt);
		drain();
		write_reg(REG_OCTAVE_COUNT, octs);
		write_reg(REG_BASE_SEED, seed);
		write_reg(REG_FREQ_STEP, fstep);
		write_reg(REG_AMP_STEP, astep);
		@(posedge clk);
		phases++;
		for (int i = 0; i < cnt; i++)
			send_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	point_row_t dir_rows[] = '{
		'{4, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1, 18'sd0},
		'{4, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b1, 18'sd0},
		'{4, 32'shFFFF_0000, 32'sh7FFF_0000, 32'sh8000_0000, 1'b1, 18'sd0},
		'{4, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 18'sd0},
		'{4, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 18'sd0},
		'{4, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh0000_8000, 1'b0, 18'sd0},
		'{4, 32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000, 1'b0, 18'sd0},
		'{4, 32'sh0000_FFFF, 32'sh0001_7FFF, 32'shFFFE_4000, 1'b0, 18'sd0},
		'{4, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_CCCC, 1'b0, 18'sd0},
		'{4, 32'sh0012_3456, 32'shFFED_CBA9, 32'sh0000_0100, 1'b0, 18'sd0},
		'{0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1234_5678, 1'b1, 18'sd0},
		'{0, 32'sh0000_8000, 32'sh0000_4000, 32'sh0000_2000, 1'b1, 18'sd0},
		'{1, 32'sh0000_8000, 32'sh0000_4000, 32'sh0000_2000, 1'b0, 18'sd0},
		'{1, 32'sh0003_C000, 32'shFFFA_1000, 32'sh0000_0001, 1'b0, 18'sd0},
		'{16, 32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b1, 18'sd0},
		'{16, 32'sh0000_1234, 32'sh0005_8765, 32'shFFF0_0F0F, 1'b0, 18'sd0},
		'{31, 32'sh8000_0001, 32'sh7FFF_FFFE, 32'sh0000_FFFF, 1'b0, 18'sd0},
		'{31, 32'sh0000_0001, 32'shFFFF_FFFF, 32'sh0000_0000, 1'b0, 18'sd0}
	};

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_coord = '0;
		y_coord = '0;
		z_coord = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		octave_cnt = OCTAVE_COUNT_RST;
		seed_reg = BASE_SEED_RST;
		lacunarity = FREQ_STEP_RST;
		gain_reg = AMP_STEP_RST;
		pinned = 1'b0;
		pinned_val = '0;
		errors = 0;
		accepted = 0;
		results = 0;
		phases = 0;
		jitter = 1'b1;
		stall_req = 0;
		stall_seen = 0;
		hold_left = 0;
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].octs != octave_cnt) begin
				drain();
				write_reg(REG_OCTAVE_COUNT, dir_rows[i].octs);
				@(posedge clk);
			end
			pinned <= dir_rows[i].pin;
			pinned_val <= dir_rows[i].val;
			send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z);
		end
		drain();
		pinned <= 1'b0;

		// junk index must leave every register alone
		write_reg(4'd9, 32'hFFFF_FFFF);
		write_reg(4'd15, 32'h0000_0000);

		run_phase(16, 32'hFFFF_FFFF, 32'h3_FFFF, 32'h1_0000, 12);
		run_phase(31, 32'h0, 32'h0, 32'h1_FFFF, 12);
		run_phase(1, 32'h0, 32'h1_0000, 32'h0, 20);
		run_phase(5, 32'h8000_0000, 32'h0_FFFF, 32'h0_0001, 20);

		jitter = 1'b0;
		drain();
		stall_req++;
		run_phase(2, 32'hDEAD_BEEF, 32'h2_0000, 32'h0_8000, 40);
		jitter = 1'b1;

		for (int p = 0; p < 9; p++)
			run_phase(($urandom_range(9) < 7) ? $urandom_range(0, 5) : $urandom_range(6, 31),
				$urandom, $urandom_range(0, 2 ** 18 - 1), $urandom_range(0, 2 ** 17 - 1), 38);

		drain();
		repeat (100)
			@(posedge clk);
		$display("Ran %0d sample points over %0d register settings, %0d results checked.",
			accepted, phases, results);
		$display("Included zero and clamped octave counts, gain above one, shrinking frequency.");
		if (errors == 0 && noise_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#40ms;
		$display("Timed out with %0d results outstanding.", noise_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
